// File: src/kbi_pkg.sv
// kbi_pkg: shared types and constants of the keyframe bone interpolator
// depends on nothing; imported by keyframe_bone_interpolator_core
package kbi_pkg;

  localparam int KEY_W   = 6;   // keyframe index bits (64 keys)
  localparam int BONE_W  = 5;   // bone index bits (32 bones)
  localparam int MAX_KEYS  = 1 << KEY_W;
  localparam int MAX_BONES = 1 << BONE_W;
  localparam int LEN_W   = 20;  // stored key length
  localparam int FRAME_W = 49;  // kind + three 16-bit raws

  localparam logic [1:0] FUNC_KEY  = 2'd0;
  localparam logic [1:0] FUNC_BONE = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  localparam logic [2:0] REG_KEY_COUNT  = 3'd0;
  localparam logic [2:0] REG_LOOP_START = 3'd1;
  localparam logic [2:0] REG_ANIM_BONES = 3'd2;
  localparam logic [2:0] REG_MODEL_BONES = 3'd3;
  localparam logic [2:0] REG_STOP       = 3'd4;
  localparam logic [2:0] REG_WAIT       = 3'd5;
  localparam logic [2:0] REG_ANGLE_MODE = 3'd6;

  // reciprocal of 90 scaled by 2^37, one less than the rounded-down value
  localparam logic [30:0] RECIP_90  = 31'd1527099482;
  // reciprocal of 360 scaled by 2^20, rounded up
  localparam logic [11:0] RECIP_360 = 12'd2913;
  localparam logic signed [31:0] OUT_LIMIT = 32'sd200000000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LEN, ST_LEN2, ST_DIV, ST_BRD, ST_CV1, ST_CV2,
    ST_DIF, ST_WRP, ST_MUL, ST_OUT
  } state_t;

endpackage

// File: src/keyframe_bone_interpolator_core.sv
// keyframe_bone_interpolator_core: top level of the keyframe bone interpolator
// depends on kbi_pkg for types, codes and constants
//
// Load words (key length, bone frame) are taken while idle and go straight
// into the key-length and bone-frame memories. A tick word reads the current
// key length, advances the frame, reads the new key length and then runs a
// 16-step restoring divider for the blend factor, one quotient bit per cycle;
// the divider is skipped when the key length is zero or the elapsed time has
// reached it. Each bone then passes through a read of the current and
// successor frame from the two read ports of the bone memory, angle
// conversion, difference, wrap, one multiply and saturation, and waits in its
// last step while the output register is still full and out_ready is low.
// The next word is taken once the last result is in the output register. The
// memories need no clearing pass after reset.
module keyframe_bone_interpolator_core import kbi_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // apb configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // input words
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          func,
  input  logic [5:0]          key_index,
  input  logic [4:0]          bone_index,
  input  logic [15:0]         key_length,
  input  logic                bone_kind,
  input  logic signed [15:0]  value_x,
  input  logic signed [15:0]  value_y,
  input  logic signed [15:0]  value_z,
  input  logic [19:0]         tick_delta,
  // result words
  output logic                out_valid,
  input  logic                out_ready,
  output logic [4:0]          out_bone,
  output logic                is_translation,
  output logic signed [28:0]  out_a,
  output logic signed [28:0]  out_b,
  output logic signed [28:0]  out_c,
  output logic [5:0]          frame_now,
  output logic                wait_released,
  output logic                last
);

  // configuration registers
  logic [6:0] key_count;
  logic [5:0] loop_start, anim_bone_count, model_bone_count;
  logic       stop_at_end, angle_mode;
  logic [7:0] wait_loop_count;

  // animation state
  state_t              state, state_next;
  logic [KEY_W-1:0]    frame_index, nxt_frame;
  logic [31:0]         elapsed;
  logic                halted, waiter_armed, released;
  logic [7:0]          loops_left;
  logic [19:0]         delta;
  logic [16:0]         fact;
  logic [LEN_W-1:0]    div_rem, len_r;
  logic [15:0]         quo;
  logic [4:0]          div_cnt;
  logic [BONE_W:0]     bone_cnt;

  // memories
  logic [LEN_W-1:0]   key_mem [MAX_KEYS];
  logic [FRAME_W-1:0] bone_mem [MAX_KEYS*MAX_BONES];
  logic [LEN_W-1:0]   key_rd;
  logic [FRAME_W-1:0] cur_rd, nxt_rd;
  logic [KEY_W-1:0]   key_raddr;
  logic               key_re, bone_re;

  logic cfg_we, in_fire;
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign in_fire = in_valid && in_ready;

  // register read mux
  always_comb begin
    case (paddr[4:2])
      REG_KEY_COUNT:   prdata = {25'd0, key_count};
      REG_LOOP_START:  prdata = {26'd0, loop_start};
      REG_ANIM_BONES:  prdata = {26'd0, anim_bone_count};
      REG_MODEL_BONES: prdata = {26'd0, model_bone_count};
      REG_STOP:        prdata = {31'd0, stop_at_end};
      REG_WAIT:        prdata = {24'd0, wait_loop_count};
      REG_ANGLE_MODE:  prdata = {31'd0, angle_mode};
      default:         prdata = 32'd0;
    endcase
  end

  // clamped counts
  logic [6:0]       nk;
  logic [KEY_W-1:0] ls;
  logic [5:0]       nb, nb_min;
  always_comb begin
    if (key_count == 7'd0) nk = 7'd1;
    else if (key_count > 7'(MAX_KEYS)) nk = 7'(MAX_KEYS);
    else nk = key_count;
    ls = ({1'b0, loop_start} < nk) ? loop_start : KEY_W'(nk - 7'd1);
    nb_min = (anim_bone_count < model_bone_count) ? anim_bone_count : model_bone_count;
    nb = (nb_min > 6'(MAX_BONES)) ? 6'(MAX_BONES) : nb_min;
  end

  // frame advance, evaluated with the current key length
  logic [31:0]      el_sum, el_new;
  logic [6:0]       nf_inc;
  logic [KEY_W-1:0] nf;
  logic             adv, wrap_end, halt_new;
  logic [7:0]       loops_dec;
  always_comb begin
    el_sum    = elapsed + {12'd0, delta};
    adv       = el_sum > {12'd0, key_rd};
    nf_inc    = {1'b0, frame_index} + 7'd1;
    wrap_end  = adv && (nf_inc >= nk);
    halt_new  = wrap_end && stop_at_end;
    loops_dec = loops_left - 8'd1;
    el_new    = el_sum;
    nf        = frame_index;
    if (adv) begin
      el_new = 32'd0;
      if (!wrap_end) nf = KEY_W'(nf_inc);
      else if (stop_at_end) el_new = {12'd0, key_rd};
      else nf = ls;
    end
  end

  logic [6:0] nf_next;
  assign nf_next = {1'b0, nf} + 7'd1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_fire && func == FUNC_TICK && !halted) state_next = ST_LEN;
      ST_LEN:  state_next = ST_LEN2;
      ST_LEN2: begin
        if (nb == 6'd0) state_next = ST_IDLE;
        else if (key_rd == '0 || elapsed >= {12'd0, key_rd}) state_next = ST_BRD;
        else state_next = ST_DIV;
      end
      ST_DIV:  if (div_cnt == 5'd15) state_next = ST_BRD;
      ST_BRD:  state_next = ST_CV1;
      ST_CV1:  state_next = ST_CV2;
      ST_CV2:  state_next = ST_DIF;
      ST_DIF:  state_next = ST_WRP;
      ST_WRP:  state_next = ST_MUL;
      ST_MUL:  state_next = ST_OUT;
      ST_OUT: begin
        if (!out_valid || out_ready)
          state_next = (bone_cnt + 1'b1 == {1'b0, nb}) ? ST_IDLE : ST_BRD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = (state == ST_IDLE);
    key_re    = 1'b0;
    bone_re   = 1'b0;
    key_raddr = frame_index;
    case (state)
      ST_IDLE: key_re = in_fire && func == FUNC_TICK;
      ST_LEN: begin
        key_re    = 1'b1;
        key_raddr = nf;
      end
      ST_BRD:  bone_re = 1'b1;
      default: ;
    endcase
  end

  // key length memory
  always_ff @(posedge clk) begin
    if (in_fire && func == FUNC_KEY)
      key_mem[key_index] <= angle_mode ? ({4'd0, key_length} << 4) - {4'd0, key_length}
                                       : {4'd0, key_length};
    if (key_re) key_rd <= key_mem[key_raddr];
  end

  // bone frame memory, two read ports
  always_ff @(posedge clk) begin
    if (in_fire && func == FUNC_BONE)
      bone_mem[{key_index, bone_index}] <= {bone_kind, value_x, value_y, value_z};
    if (bone_re) begin
      cur_rd <= bone_mem[{frame_index, bone_cnt[BONE_W-1:0]}];
      nxt_rd <= bone_mem[{nxt_frame, bone_cnt[BONE_W-1:0]}];
    end
  end

  // state register, configuration and tick control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      key_count <= 7'd1; loop_start <= '0; anim_bone_count <= '0;
      model_bone_count <= '0; stop_at_end <= 1'b0; wait_loop_count <= '0;
      angle_mode <= 1'b0;
      frame_index <= '0; elapsed <= '0; halted <= 1'b0;
      loops_left <= '0; waiter_armed <= 1'b0; released <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (paddr[4:2])
          REG_KEY_COUNT:   key_count <= pwdata[6:0];
          REG_LOOP_START:  loop_start <= pwdata[5:0];
          REG_ANIM_BONES:  anim_bone_count <= pwdata[5:0];
          REG_MODEL_BONES: model_bone_count <= pwdata[5:0];
          REG_STOP:        stop_at_end <= pwdata[0];
          REG_WAIT: begin
            wait_loop_count <= pwdata[7:0];
            loops_left      <= pwdata[7:0];
            waiter_armed    <= pwdata[7:0] != 8'd0;
          end
          REG_ANGLE_MODE:  angle_mode <= pwdata[0];
          default: ;
        endcase
      end
      if (state == ST_LEN) begin
        frame_index <= nf;
        elapsed     <= el_new;
        released    <= 1'b0;
        if (halt_new) halted <= 1'b1;
        if (wrap_end && waiter_armed) begin
          loops_left <= loops_dec;
          if (loops_dec == 8'd0) begin
            released     <= 1'b1;
            waiter_armed <= 1'b0;
          end
        end
      end
    end
  end

  // tick datapath: successor frame, blend factor divider, bone counter
  always_ff @(posedge clk) begin
    if (in_fire) delta <= tick_delta;
    case (state)
      ST_LEN: nxt_frame <= (nf_next < nk) ? KEY_W'(nf_next) : ls;
      ST_LEN2: begin
        len_r    <= key_rd;
        div_rem  <= elapsed[LEN_W-1:0];
        div_cnt  <= '0;
        bone_cnt <= '0;
        if (key_rd == '0) fact <= '0;
        else fact <= 17'h10000;
      end
      ST_DIV: begin
        if ({div_rem, 1'b0} >= {1'b0, len_r}) begin
          div_rem <= LEN_W'({div_rem, 1'b0} - {1'b0, len_r});
          quo     <= {quo[14:0], 1'b1};
        end else begin
          div_rem <= LEN_W'({div_rem, 1'b0});
          quo     <= {quo[14:0], 1'b0};
        end
        div_cnt <= div_cnt + 5'd1;
      end
      ST_BRD: if (div_cnt == 5'd16) fact <= {1'b0, quo};
      ST_OUT: if (!out_valid || out_ready) bone_cnt <= bone_cnt + 1'b1;
      default: ;
    endcase
  end

  // per-bone lanes: 0..2 current x,y,z, 3..5 successor x,y,z
  logic                tr;
  logic signed [15:0]  raw [6];
  logic [61:0]         prod90 [6];
  logic [30:0]         x_r [6];
  logic signed [29:0]  q16 [6];
  logic signed [30:0]  dlt [3];
  logic signed [14:0]  tw [3];
  logic signed [9:0]   wv [3];
  logic signed [48:0]  bprod [3];
  logic signed [31:0]  res [3];

  assign tr = cur_rd[48];

  always_comb begin
    raw[0] = cur_rd[47:32]; raw[1] = cur_rd[31:16]; raw[2] = cur_rd[15:0];
    raw[3] = nxt_rd[47:32]; raw[4] = nxt_rd[31:16]; raw[5] = nxt_rd[15:0];
  end

  // absolute raw values, 17 bits so that 32768 fits
  logic [16:0] absr [6];
  always_comb begin
    for (int j = 0; j < 6; j++)
      absr[j] = raw[j][15] ? 17'(-$signed({raw[j][15], raw[j]})) : {1'b0, raw[j]};
  end

  // conversion stage one: multiply by the reciprocal of 90
  always_ff @(posedge clk) begin
    if (state == ST_CV1) begin
      for (int j = 0; j < 6; j++) begin
        x_r[j]    <= {absr[j][15:0], 15'd0} + 31'd45;
        prod90[j] <= ({absr[j][15:0], 15'd0} + 31'd45) * RECIP_90;
      end
    end
  end

  // conversion stage two: quotient correction and sign, or plain scaling
  logic [24:0] q0 [6];
  logic [31:0] rm [6];
  logic [24:0] qc [6];
  always_comb begin
    for (int j = 0; j < 6; j++) begin
      q0[j] = prod90[j][61:37];
      rm[j] = {1'b0, x_r[j]} - ({7'd0, q0[j]} * 32'd90);
      qc[j] = (rm[j] >= 32'd90) ? q0[j] + 25'd1 : q0[j];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CV2) begin
      for (int j = 0; j < 6; j++) begin
        if (tr) q16[j] <= 30'(raw[j]) <<< 2;
        else if (!angle_mode) q16[j] <= 30'(raw[j]) * 30'sd5760;
        else q16[j] <= raw[j][15] ? -$signed({5'd0, qc[j]}) : $signed({5'd0, qc[j]});
      end
    end
  end

  // difference and whole degrees, truncated toward zero
  logic signed [30:0] dd [3];
  logic        [30:0] dmag [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dd[j]   = 31'(q16[j+3]) - 31'(q16[j]);
      dmag[j] = dd[j][30] ? 31'(-dd[j]) : dd[j];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIF) begin
      for (int j = 0; j < 3; j++) begin
        dlt[j] <= dd[j];
        tw[j]  <= dd[j][30] ? -$signed({1'b0, dmag[j][29:16]}) : $signed({1'b0, dmag[j][29:16]});
      end
    end
  end

  // wrap whole degrees into -180..179
  logic [13:0] tmag [3];
  logic [25:0] tq [3];
  logic [13:0] trem [3];
  logic [8:0]  rr [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      tmag[j] = tw[j][14] ? 14'(-tw[j]) : 14'(tw[j]);
      tq[j]   = tmag[j] * RECIP_360;
      trem[j] = tmag[j] - ({8'd0, tq[j][25:20]} * 14'd360);
      rr[j]   = (tw[j][14] && trem[j] != 14'd0) ? 9'(14'd360 - trem[j]) : trem[j][8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WRP)
      for (int j = 0; j < 3; j++)
        wv[j] <= (rr[j] >= 9'd180) ? $signed({1'b0, rr[j]}) - 10'sd360 : $signed({1'b0, rr[j]});
  end

  // blend multiply
  always_ff @(posedge clk) begin
    if (state == ST_MUL)
      for (int j = 0; j < 3; j++)
        bprod[j] <= (tr ? dlt[j] : 31'(wv[j])) * $signed({1'b0, fact});
  end

  // add, saturate
  logic signed [48:0] sum [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sum[j] = 49'(q16[j]) + (tr ? (bprod[j] >>> 16) : bprod[j]);
      if (sum[j] > 49'(OUT_LIMIT)) res[j] = OUT_LIMIT;
      else if (sum[j] < -49'(OUT_LIMIT)) res[j] = -OUT_LIMIT;
      else res[j] = 32'(sum[j]);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (state == ST_OUT && (!out_valid || out_ready)) begin
      out_bone       <= bone_cnt[BONE_W-1:0];
      is_translation <= tr;
      out_a          <= res[0][28:0];
      out_b          <= tr ? res[1][28:0] : res[2][28:0];
      out_c          <= tr ? res[2][28:0] : res[1][28:0];
      frame_now      <= frame_index;
      wait_released  <= released;
      last           <= (bone_cnt + 1'b1 == {1'b0, nb});
    end
  end

`ifndef SYNTHESIS
  // once halted, only reset leaves the halt
  a_halt_holds: assert property (@(posedge clk) disable iff (rst) halted |=> halted)
    else $error("halt released without reset");
  // the blend factor never exceeds one
  a_fact_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL |-> fact <= 17'h10000)
    else $error("blend factor out of range");
  // the bone counter stays below the bone count while bones are worked
  a_bone_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT |-> bone_cnt < {1'b0, nb})
    else $error("bone counter past bone count");
`endif

endmodule
